FILE: hw/rtl/b64rl_pkg.sv
// Package with shared types and the character classifier of the base64 rotate-left decoder.
`default_nettype none

package b64rl_pkg;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_has_data;
    logic       out_last;
  } out_item_t;

  // One decode job handed from the front end to the back end.
  // A job with byte_cnt of zero is a bare end marker.
  typedef struct packed {
    logic [23:0] acc;
    logic [1:0]  byte_cnt;
    logic        last;
  } job_t;

  typedef enum logic [1:0] {
    CK_DATA,
    CK_PAD,
    CK_OTHER
  } char_kind_e;

  typedef struct packed {
    char_kind_e kind;
    logic [5:0] value;
  } char_class_t;

  localparam logic [7:0] CharPad   = 8'h3D;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [5:0] LowerBase = 6'd26;
  localparam logic [5:0] DigitBase = 6'd52;
  localparam logic [5:0] PlusValue = 6'd62;
  localparam logic [5:0] SlashValue = 6'd63;
  localparam logic [2:0] PadMax    = 3'd4;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    r.kind  = CK_OTHER;
    r.value = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.kind  = CK_DATA;
      r.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.kind  = CK_DATA;
      r.value = 6'(c - 8'h61) + LowerBase;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.kind  = CK_DATA;
      r.value = 6'(c - 8'h30) + DigitBase;
    end else if (c == CharPlus) begin
      r.kind  = CK_DATA;
      r.value = PlusValue;
    end else if (c == CharSlash) begin
      r.kind  = CK_DATA;
      r.value = SlashValue;
    end else if (c == CharPad) begin
      r.kind  = CK_PAD;
    end
    return r;
  endfunction

  function automatic logic [7:0] rotl1(input logic [7:0] b);
    return {b[6:0], b[7]};
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/base64_decode_rotate_left_top.sv
// Top level of the streaming base64 decoder with one-bit left rotate per byte.
//
// Usage: characters enter through a queue-style port. A transaction is taken at a
// rising edge where push is high and full is low; in_data_i carries the character
// and an end flag that marks the final character of a string. Results leave through
// a second queue-style port: while empty is low the oldest result is on out_data_o,
// and a rising edge with pop high takes it.
// Every fourth character of a group yields up to three decoded bytes, each rotated
// left by one bit. A padded group closes the data; later characters are ignored until
// the end flag. An end flag that yields no byte produces one marker result with
// out_has_data low. The final result of a string has out_last high.
// The character that closes a group writes its job into the job queue; the back end then
// loads the first byte into the result register, and the other bytes of that group follow
// one per cycle while the receiver takes each result.
// Throughput is one character per cycle while full is low; the back end emits one byte
// per cycle while results are taken, which covers the three bytes per four characters of
// normal text. A job queue of QueueDepth entries lets the front end keep accepting while
// the receiver stalls; full rises only when that queue has filled. Reset clears the group
// state, the queue and the valid flag of the result register; no clearing pass.
`default_nettype none

module base64_decode_rotate_left_top
  import b64rl_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push,
  output logic           full,
  input  wire in_item_t  in_data_i,
  output logic           empty,
  input  wire logic      pop,
  output out_item_t      out_data_o
);

  job_t job_in, job_head;
  logic job_push, job_pop, job_valid, accept, out_valid;

  // The front end stalls only on a full job queue.
  assign accept = push && !full;

  b64rl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_data_i),
    .job_o      (job_in),
    .job_push_o (job_push)
  );

  b64rl_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_push),
    .push_data_i (job_in),
    .full_o      (full),
    .pop_i       (job_pop),
    .head_o      (job_head),
    .valid_o     (job_valid)
  );

  b64rl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_head),
    .job_valid_i (job_valid),
    .job_pop_o   (job_pop),
    .out_o       (out_data_o),
    .out_valid_o (out_valid),
    .out_pop_i   (pop)
  );

  assign empty = !out_valid;

endmodule

`default_nettype wire

FILE: hw/rtl/b64rl_front.sv
// Front end: takes characters, classifies them and groups them into decode jobs.
`default_nettype none

module b64rl_front
  import b64rl_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     accept_i,
  input  wire in_item_t item_i,
  output job_t          job_o,
  output logic          job_push_o
);

  logic [23:0] acc_q, acc_d;
  logic [1:0]  slot_q, slot_d;
  logic [2:0]  pad_q, pad_d;
  logic        fin_q, fin_d;

  char_class_t cls;
  logic [23:0] acc_shift;
  logic [2:0]  pad_inc;
  logic [1:0]  emit_cnt;

  always_comb begin
    cls       = classify(item_i.in_char);
    acc_shift = acc_q;
    pad_inc   = pad_q;
    case (cls.kind)
      CK_DATA: acc_shift = {acc_q[17:0], cls.value};
      CK_PAD: begin
        acc_shift = {acc_q[17:0], 6'd0};
        if (pad_q < PadMax) pad_inc = pad_q + 3'd1;
      end
      default: acc_shift = acc_q;
    endcase

    acc_d      = acc_q;
    slot_d     = slot_q;
    pad_d      = pad_q;
    fin_d      = fin_q;
    emit_cnt   = 2'd0;
    job_push_o = 1'b0;

    if (accept_i) begin
      if (!fin_q) begin
        if (slot_q == 2'd3) begin
          emit_cnt = (pad_inc >= 3'd3) ? 2'd0 : 2'(3'd3 - pad_inc);
          if (pad_inc != 3'd0) fin_d = 1'b1;
          acc_d  = '0;
          slot_d = 2'd0;
          pad_d  = 3'd0;
        end else begin
          acc_d  = acc_shift;
          pad_d  = pad_inc;
          slot_d = slot_q + 2'd1;
        end
      end
      job_push_o = (emit_cnt != 2'd0) || item_i.in_end;
      if (item_i.in_end) begin
        acc_d  = '0;
        slot_d = 2'd0;
        pad_d  = 3'd0;
        fin_d  = 1'b0;
      end
    end

    job_o.acc      = acc_shift;
    job_o.byte_cnt = emit_cnt;
    job_o.last     = item_i.in_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      slot_q <= '0;
      pad_q  <= '0;
      fin_q  <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      slot_q <= slot_d;
      pad_q  <= pad_d;
      fin_q  <= fin_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/b64rl_fifo.sv
// Job queue between the front end and the back end.
`default_nettype none

module b64rl_fifo
  import b64rl_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t push_data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output job_t      head_o,
  output logic      valid_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == LastIdx) ? '0 : wr_q + PtrW'(1);
    if (do_pop) rd_d = (rd_q == LastIdx) ? '0 : rd_q + PtrW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CntW'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/b64rl_back.sv
// Back end: splits each job into rotated bytes and holds the result register.
`default_nettype none

module b64rl_back
  import b64rl_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire job_t job_i,
  input  wire logic job_valid_i,
  output logic      job_pop_o,
  output out_item_t out_o,
  output logic      out_valid_o,
  input  wire logic out_pop_i
);

  logic [1:0] idx_q, idx_d;
  logic       ovalid_q, ovalid_d;
  out_item_t  out_q, out_d;
  logic [1:0] n_res;
  logic       final_byte, load, taken;
  logic [7:0] sel_byte;

  always_comb begin
    n_res      = (job_i.byte_cnt == 2'd0) ? 2'd1 : job_i.byte_cnt;
    final_byte = (idx_q == n_res - 2'd1);
    case (idx_q)
      2'd0:    sel_byte = job_i.acc[23:16];
      2'd1:    sel_byte = job_i.acc[15:8];
      default: sel_byte = job_i.acc[7:0];
    endcase

    taken = out_pop_i && ovalid_q;
    load  = job_valid_i && (!ovalid_q || taken);

    out_d    = out_q;
    idx_d    = idx_q;
    ovalid_d = ovalid_q;
    if (taken) ovalid_d = 1'b0;
    if (load) begin
      ovalid_d           = 1'b1;
      out_d.out_has_data = (job_i.byte_cnt != 2'd0);
      out_d.out_byte     = out_d.out_has_data ? rotl1(sel_byte) : 8'd0;
      out_d.out_last     = job_i.last && final_byte;
      idx_d              = final_byte ? 2'd0 : idx_q + 2'd1;
    end
    job_pop_o = load && final_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o       = out_q;
  assign out_valid_o = ovalid_q;

endmodule

`default_nettype wire

FILE: hw/rtl/b64rl_checker.sv
// Port-level checker for the base64 rotate-left decoder, with its bind.
`default_nettype none

module b64rl_checker
  import b64rl_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      push,
  input wire logic      full,
  input wire logic      empty,
  input wire logic      pop,
  input wire out_item_t out_data_o
);

  // A waiting result that is not taken stays and keeps its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_data_o)))
    else $error("result changed while stalled");

  // An end marker always closes its string.
  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_data_o.out_has_data) |-> out_data_o.out_last)
    else $error("end marker without last flag");

  // An end marker carries a zero byte.
  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_data_o.out_has_data) |-> (out_data_o.out_byte == 8'd0))
    else $error("end marker with nonzero byte");

  // With nothing waiting and no transaction in during the sampled past cycles, no result appears.
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(empty) && $past(!(push && !full)) && $past(empty, 2)
     && $past(!(push && !full), 2)) |-> empty)
    else $error("result appeared without a transaction in");

endmodule

bind base64_decode_rotate_left_top b64rl_checker u_b64rl_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .out_data_o (out_data_o)
);

`default_nettype wire
